[rtl/assert_macros.svh]
// assertion macros shared by the rtl files
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_SAME(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/bcd_pkg.sv]
// types, codes and helpers for the byte command decoder
// no dependencies
package bcd_pkg;

  typedef enum logic [2:0] {
    CMD_VOLUME = 3'd0,
    CMD_DUTY   = 3'd1,
    CMD_PLAY   = 3'd2,
    CMD_LOGS   = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_APPEND = 3'd5,
    CMD_STOP   = 3'd6,
    CMD_RTC    = 3'd7
  } cmd_e;

  localparam logic [7:0] OP_VOLUME    = 8'h00;
  localparam logic [7:0] OP_PLAY      = 8'h01;
  localparam logic [7:0] OP_LOGS      = 8'h02;
  localparam logic [7:0] OP_DUTY      = 8'h04;
  localparam logic [7:0] OP_SCHEDULE  = 8'h05;
  localparam logic [7:0] OP_SCHED_END = 8'h0D;
  localparam logic [7:0] OP_SET_TIME  = 8'h0F;

  localparam logic [7:0] EVENTS_RESET = 8'd180;

  localparam logic [7:0] RTC_MINUTE = 8'd0;
  localparam logic [7:0] RTC_HOUR   = 8'd1;
  localparam logic [7:0] RTC_DAY    = 8'd2;
  localparam logic [7:0] RTC_MONTH  = 8'd3;

  typedef struct packed {
    logic [7:0] track;
    logic [7:0] folder;
    logic [7:0] stop;
    logic [7:0] start;
    logic [7:0] day;
    logic [7:0] month;
  } entry_t;

  typedef struct packed {
    cmd_e       command;
    logic       append_entry;
    logic [7:0] arg_month;
    logic [7:0] arg_day;
    entry_t     ent;
  } result_t;

  // binary below 60 to packed bcd
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [3:0] tens;
    logic [7:0] rem;
    tens = 4'd0;
    rem  = v;
    if (v >= 8'd50) begin
      tens = 4'd5;
      rem  = v - 8'd50;
    end else if (v >= 8'd40) begin
      tens = 4'd4;
      rem  = v - 8'd40;
    end else if (v >= 8'd30) begin
      tens = 4'd3;
      rem  = v - 8'd30;
    end else if (v >= 8'd20) begin
      tens = 4'd2;
      rem  = v - 8'd20;
    end else if (v >= 8'd10) begin
      tens = 4'd1;
      rem  = v - 8'd10;
    end
    return {tens, rem[3:0]};
  endfunction

endpackage

[rtl/byte_command_decoder.sv]
// byte command decoder top level: parser state machine and output staging
// depends on bcd_pkg and assert_macros.svh
// Takes one host byte per beat on the slave stream and emits at most one command
// beat per byte on the master stream. Every byte is decoded in the cycle it is
// accepted; its command, if any, goes to the output register, or to the skid
// register while that is held. The two entries keep the slave side ready while
// one command waits, so the sustained rate is one byte per cycle; tready drops
// only when both are full. The user must write the event limit register via
// cfg_we_i / cfg_wdata_i only while the block is idle; it does not enforce this.
`include "assert_macros.svh"

module byte_command_decoder
  import bcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // arg_month, arg_day, arg_start, arg_stop, arg_folder, arg_track
  output logic [47:0] m_axis_tdata,
  output logic [3:0]  m_axis_tuser    // command, append_entry
);

  typedef enum logic [3:0] {
    S_IDLE, S_VOLUME, S_DUTY, S_FOLDER, S_TRACK,
    S_MONTH, S_DAY, S_START, S_STOP, S_EFOLDER, S_ETRACK, S_END,
    S_TMIN, S_THOUR, S_TDAY, S_TMONTH
  } state_e;

  state_e     mode_q, mode_d;
  logic [7:0] max_events_q;
  logic [7:0] folder_q, folder_d;
  entry_t     entry_q, entry_d;
  logic [7:0] count_q, count_d;

  result_t    res_d, out_q, skid_q;
  logic       res_valid;
  logic       out_valid_q, skid_valid_q;
  logic       s_accept, m_pop, push;
  logic       entry_ok;
  logic [7:0] b;

  assign b             = s_axis_tdata;
  assign s_axis_tready = !skid_valid_q;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_pop         = out_valid_q && m_axis_tready;
  assign push          = s_accept && res_valid;
  assign entry_ok      = (entry_q.month != 8'd0) || (entry_q.day != 8'd0);

  always_comb begin
    mode_d    = mode_q;
    folder_d  = folder_q;
    entry_d   = entry_q;
    count_d   = count_q;
    res_d     = '0;
    res_valid = 1'b0;
    unique case (mode_q)
      S_IDLE: begin
        unique case (b)
          OP_VOLUME:   mode_d = S_VOLUME;
          OP_PLAY:     mode_d = S_FOLDER;
          OP_DUTY:     mode_d = S_DUTY;
          OP_SET_TIME: mode_d = S_TMIN;
          OP_LOGS: begin
            res_d.command = CMD_LOGS;
            res_valid     = 1'b1;
          end
          OP_SCHEDULE: begin
            entry_d       = '0;
            count_d       = 8'd0;
            mode_d        = S_MONTH;
            res_d.command = CMD_CLEAR;
            res_valid     = 1'b1;
          end
          default: ;
        endcase
      end
      S_VOLUME, S_DUTY: begin
        res_d.command   = (mode_q == S_VOLUME) ? CMD_VOLUME : CMD_DUTY;
        res_d.arg_month = b;
        res_valid       = 1'b1;
        mode_d          = S_IDLE;
      end
      S_FOLDER: begin
        folder_d = b;
        mode_d   = S_TRACK;
      end
      S_TRACK: begin
        res_d.command   = CMD_PLAY;
        res_d.arg_month = folder_q;
        res_d.arg_day   = b;
        res_valid       = 1'b1;
        mode_d          = S_IDLE;
      end
      S_MONTH: begin
        if (b == OP_SCHED_END) begin
          mode_d = S_IDLE;
          if (entry_ok) begin
            res_d.command   = CMD_APPEND;
            res_d.arg_month = entry_q.month;
            res_d.arg_day   = entry_q.day;
            res_d.ent       = entry_q;
            res_valid       = 1'b1;
          end
        end else if (count_q > max_events_q) begin
          res_d.command = CMD_STOP;
          res_valid     = 1'b1;
          mode_d        = S_END;
          if (entry_ok) begin
            res_d.append_entry = 1'b1;
            res_d.arg_month    = entry_q.month;
            res_d.arg_day      = entry_q.day;
            res_d.ent          = entry_q;
          end
        end else begin
          if (entry_ok) begin
            res_d.command   = CMD_APPEND;
            res_d.arg_month = entry_q.month;
            res_d.arg_day   = entry_q.day;
            res_d.ent       = entry_q;
            res_valid       = 1'b1;
          end
          entry_d.month = b;
          mode_d        = S_DAY;
        end
      end
      S_DAY: begin
        entry_d.day = b;
        mode_d      = S_START;
      end
      S_START: begin
        entry_d.start = b;
        mode_d        = S_STOP;
      end
      S_STOP: begin
        entry_d.stop = b;
        mode_d       = S_EFOLDER;
      end
      S_EFOLDER: begin
        entry_d.folder = b;
        mode_d         = S_ETRACK;
      end
      S_ETRACK: begin
        entry_d.track = b;
        if (count_q != 8'hFF) begin
          count_d = count_q + 8'd1;
        end
        mode_d = S_MONTH;
      end
      S_END: begin
        if (b == OP_SCHED_END) begin
          mode_d = S_IDLE;
        end
      end
      S_TMIN: begin
        if (b < 8'd60) begin
          res_d.command   = CMD_RTC;
          res_d.arg_month = RTC_MINUTE;
          res_d.arg_day   = to_bcd(b);
          res_valid       = 1'b1;
          mode_d          = S_THOUR;
        end
      end
      S_THOUR: begin
        if (b < 8'd24) begin
          res_d.command   = CMD_RTC;
          res_d.arg_month = RTC_HOUR;
          res_d.arg_day   = to_bcd(b);
          res_valid       = 1'b1;
          mode_d          = S_TDAY;
        end
      end
      S_TDAY: begin
        if (b <= 8'd31) begin
          res_d.command   = CMD_RTC;
          res_d.arg_month = RTC_DAY;
          res_d.arg_day   = to_bcd(b);
          res_valid       = 1'b1;
          mode_d          = S_TMONTH;
        end
      end
      S_TMONTH: begin
        if (b <= 8'd12) begin
          res_d.command   = CMD_RTC;
          res_d.arg_month = RTC_MONTH;
          res_d.arg_day   = to_bcd(b);
          res_valid       = 1'b1;
          mode_d          = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= S_IDLE;
      max_events_q <= EVENTS_RESET;
      folder_q     <= 8'd0;
      entry_q      <= '0;
      count_q      <= 8'd0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_events_q <= cfg_wdata_i;
      end
      if (s_accept) begin
        mode_q   <= mode_d;
        folder_q <= folder_d;
        entry_q  <= entry_d;
        count_q  <= count_d;
      end
      if (skid_valid_q) begin
        if (m_pop) begin
          skid_valid_q <= 1'b0;
        end
      end else if (push) begin
        if (!out_valid_q || m_pop) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (m_pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload staging, no reset
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (m_pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!out_valid_q || m_pop) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.ent.track, out_q.ent.folder, out_q.ent.stop,
                          out_q.ent.start, out_q.arg_day, out_q.arg_month};
  assign m_axis_tuser  = {out_q.append_entry, out_q.command};

  `ASSERT_SAME(a_skid_needs_out, skid_valid_q, out_valid_q)
  `ASSERT_NEXT(a_skid_drains, skid_valid_q && m_pop, out_valid_q && !skid_valid_q)
  `ASSERT_SAME(a_append_only_stop, out_valid_q && out_q.append_entry, out_q.command == CMD_STOP)
  `ASSERT_SAME(a_end_silent, s_accept && (mode_q == S_END), !res_valid)

endmodule
